[rtl/esu_pkg.sv]
`default_nettype none
package esu_pkg;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BAD    = 8'hFF;
    localparam logic [7:0] ALPHA_BASE = 8'd10;

    // decoder modes
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_ESC   = 2'd1;
    localparam logic [1:0] MODE_HEX1  = 2'd2;
    localparam logic [1:0] MODE_HEX2  = 2'd3;

    localparam int LEN_W = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8 + LEN_W;

    // output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic [LEN_W-1:0] length;
    } esu_beat_t;

    // up to two result beats produced by one input byte
    typedef struct packed {
        logic [1:0] num;
        esu_beat_t  first;
        esu_beat_t  second;
    } esu_push_t;

    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[CH_UA:CH_UZ]}) begin
            v = c - CH_UA + ALPHA_BASE;
        end else if (c inside {[CH_LA:CH_LZ]}) begin
            v = c - CH_LA + ALPHA_BASE;
        end else if (c inside {[CH_0:CH_9]}) begin
            v = c - CH_0;
        end else begin
            v = CH_BAD;
        end
        return v;
    endfunction

    function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
        return (v == {LEN_W{1'b1}}) ? v : v + LEN_W'(1);
    endfunction

endpackage
`default_nettype wire

[rtl/escape_sequence_unescaper.sv]
`default_nettype none
// channel  | dir | signals                      | beat contents
// ---------+-----+------------------------------+------------------------------------
// s_       | in  | s_tvalid s_tready s_tdata    | one source character, 0 ends string
// m_       | out | m_tvalid m_tready m_tdata    | decoded byte, length on terminator
//          |     | m_tlast                      | high on the terminator beat
//
// An input beat is registered, decoded once the output queue has room and written
// to that four-entry queue. One input beat per cycle is taken while the queue has
// two free slots; the sustained rate is set by the single output port, one result
// beat per cycle while m_tready is high, so a two-result byte needs two beats.
// Reset (aresetn low, synchronous) empties the queue and returns to plain text.
// A stalled m_ side holds the queue and then the input register; no beat is lost.
module escape_sequence_unescaper (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [esu_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] in_byte
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [esu_pkg::OUT_TDATA_W-1:0]      m_tdata,   // [7:0] out_byte, [23:8] out_length
    output logic                                 m_tlast
);
    import esu_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       room;
    logic       step;
    logic       s_fire;
    esu_push_t  push;

    assign step     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || step;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
        end
    end

    esu_decoder u_decoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_byte (in_byte_reg),
        .push    (push)
    );

    esu_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

[rtl/esu_decoder.sv]
`default_nettype none
module esu_decoder (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               step,
    input  wire logic [7:0]         in_byte,
    output esu_pkg::esu_push_t      push
);
    import esu_pkg::*;

    logic [1:0]       mode_reg, mode_next;
    logic [7:0]       high_reg, high_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0] cnt1, cnt2;
    logic [7:0]       dval;
    esu_push_t        res;

    assign cnt1 = sat_inc(count_reg);
    assign cnt2 = sat_inc(cnt1);
    assign dval = digit_value(in_byte);

    always_comb begin
        res        = '0;
        mode_next  = mode_reg;
        high_next  = high_reg;
        count_next = count_reg;
        if (in_byte == CH_NUL) begin
            if (mode_reg == MODE_ESC) begin
                res.num          = 2'd2;
                res.first.data   = CH_BSLASH;
                res.second.last  = 1'b1;
                res.second.length = cnt1;
            end else if (mode_reg inside {MODE_HEX1, MODE_HEX2}) begin
                // unfinished hex escape
                res.num          = 2'd2;
                res.first.data   = CH_BAD;
                res.second.last  = 1'b1;
                res.second.length = cnt1;
            end else begin
                res.num          = 2'd1;
                res.first.last   = 1'b1;
                res.first.length = count_reg;
            end
            mode_next  = MODE_PLAIN;
            high_next  = '0;
            count_next = '0;
        end else begin
            case (mode_reg)
                MODE_PLAIN: begin
                    if (in_byte == CH_BSLASH) begin
                        mode_next = MODE_ESC;
                    end else begin
                        res.num        = 2'd1;
                        res.first.data = in_byte;
                        count_next     = cnt1;
                    end
                end
                MODE_ESC: begin
                    mode_next      = MODE_PLAIN;
                    res.num        = 2'd1;
                    count_next     = cnt1;
                    case (in_byte)
                        CH_BSLASH: res.first.data = CH_BSLASH;
                        CH_R:      res.first.data = CH_CR;
                        CH_N:      res.first.data = CH_LF;
                        CH_T:      res.first.data = CH_TAB;
                        CH_X: begin
                            res.num    = 2'd0;
                            count_next = count_reg;
                            mode_next  = MODE_HEX1;
                        end
                        default: begin
                            // unknown escape goes out verbatim
                            res.num         = 2'd2;
                            res.first.data  = CH_BSLASH;
                            res.second.data = in_byte;
                            count_next      = cnt2;
                        end
                    endcase
                end
                MODE_HEX1: begin
                    high_next = {dval[3:0], 4'b0000};
                    mode_next = MODE_HEX2;
                end
                default: begin
                    res.num        = 2'd1;
                    res.first.data = high_reg | dval;
                    count_next     = cnt1;
                    high_next      = '0;
                    mode_next      = MODE_PLAIN;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_PLAIN;
            high_reg  <= '0;
            count_reg <= '0;
        end else if (step) begin
            mode_reg  <= mode_next;
            high_reg  <= high_next;
            count_reg <= count_next;
        end
    end

    always_comb begin
        push     = res;
        push.num = step ? res.num : 2'd0;
    end

    a_term_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && in_byte == CH_NUL |=>
            count_reg == '0 && mode_reg == MODE_PLAIN && high_reg == '0)
        else $error("state not cleared after terminator");

    a_pair_first_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        push.num == 2'd2 |-> !push.first.last && push.second.data != CH_NUL ||
            push.num == 2'd2 && push.second.last)
        else $error("terminator placed first in a pair");

    a_term_length: assert property (@(posedge aclk) disable iff (!aresetn)
        step && in_byte == CH_NUL && mode_reg == MODE_PLAIN |->
            push.num == 2'd1 && push.first.last && push.first.length == count_reg)
        else $error("terminator length mismatch");

endmodule
`default_nettype wire

[rtl/esu_out_fifo.sv]
`default_nettype none
module esu_out_fifo (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire esu_pkg::esu_push_t              push,
    output logic                                 room,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [esu_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tlast
);
    import esu_pkg::*;

    esu_beat_t             mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [OQ_CNT_W-1:0]   count_reg, count_next;
    logic                  pop;
    esu_beat_t             head;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != '0);
    // two free slots needed since one byte may give two beats
    assign room     = (count_reg <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign head     = mem[rd_ptr_reg];
    assign m_tdata  = {head.length, head.data};
    assign m_tlast  = head.last;

    assign count_next = count_reg + OQ_CNT_W'(push.num) - OQ_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2) begin
            mem[wr_ptr_reg + OQ_PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + OQ_PTR_W'(push.num);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + OQ_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= OQ_CNT_W'(OQ_DEPTH))
        else $error("output queue overflow");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.num != 2'd0 |-> room)
        else $error("push without two free slots");

    a_pop_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && push.num == 2'd0 |=> count_reg == $past(count_reg) - OQ_CNT_W'(1))
        else $error("queue count wrong after pop");

endmodule
`default_nettype wire
